// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Default saturation point of the decoded length counter
    localparam longint unsigned MaxLenDefault = 64'd65535;

    // Decoder phase
    typedef enum logic [3:0] {
        PH_IDLE   = 4'd0,
        PH_STR    = 4'd1,
        PH_ESC    = 4'd2,
        PH_HEX1   = 4'd3,
        PH_SUR_BS = 4'd4,
        PH_SUR_U  = 4'd5,
        PH_HEX2   = 4'd6
    } t_phase;

    // Result status codes
    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_DONE    = 3'd1,
        ST_NOQUOTE = 3'd2,
        ST_CTRL    = 3'd3,
        ST_ESC     = 3'd4,
        ST_HEX     = 3'd5,
        ST_SUR     = 3'd6
    } t_status;

    // Result group made by one input byte: up to four results.
    // Non-data groups carry exactly one result (last_idx == 0).
    typedef struct packed {
        logic            has;       // group holds at least one result
        logic [1:0]      last_idx;  // index of the final result
        logic [3:0][7:0] bytes;     // data bytes, bytes[0] sent first
        t_status         status;
        logic [15:0]     len;
    } t_group;

endpackage

// ----- rtl/core/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// String state and per-byte decode: turns one text byte into a result group.
// ----------------------------------------------------------------------------
module jsu_decode #(
    parameter longint unsigned MAX_LEN = jsu_pkg::MaxLenDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,     // byte in i_byte is consumed this cycle
    input  logic [7:0]      i_byte,
    output jsu_pkg::t_group o_grp
);

    localparam int CntW = $clog2(MAX_LEN + 1);
    localparam logic [CntW:0] MaxCnt = (CntW + 1)'(MAX_LEN);

    localparam logic [7:0] ChQuote  = 8'h22;
    localparam logic [7:0] ChBslash = 8'h5C;
    localparam logic [7:0] ChSlash  = 8'h2F;
    localparam logic [7:0] ChLowB   = 8'h62;
    localparam logic [7:0] ChLowF   = 8'h66;
    localparam logic [7:0] ChLowN   = 8'h6E;
    localparam logic [7:0] ChLowT   = 8'h74;
    localparam logic [7:0] ChLowR   = 8'h72;
    localparam logic [7:0] ChLowU   = 8'h75;
    localparam logic [7:0] CtrlTop  = 8'h20;

    localparam logic [15:0] HiSurLo = 16'hD800;
    localparam logic [15:0] HiSurHi = 16'hDBFF;
    localparam logic [15:0] LoSurLo = 16'hDC00;
    localparam logic [15:0] LoSurHi = 16'hDFFF;
    localparam logic [20:0] SupBase = 21'h10000;

    jsu_pkg::t_phase r_phase, n_phase;
    logic [15:0]     r_acc, n_acc;
    logic [9:0]      r_high, n_high;
    logic [1:0]      r_digits, n_digits;
    logic [CntW-1:0] r_cnt, n_cnt;

    logic            cnt_clear;
    logic            hex_ok;
    logic [3:0]      hex_v;
    logic [15:0]     acc_new;
    logic            acc_hi_sur;
    logic            acc_lo_sur;
    logic [20:0]     enc_u;
    logic [3:0][7:0] enc_bytes;
    logic [1:0]      enc_last;
    logic [15:0]     len_sat;
    logic [CntW+16:0] cnt_ext;
    logic [CntW:0]   cnt_sum;
    jsu_pkg::t_group grp;

    // Hex digit value
    always_comb begin
        hex_ok = 1'b0;
        hex_v  = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_ok = 1'b1;
            hex_v  = i_byte[3:0];
        end else if ((i_byte >= 8'h41 && i_byte <= 8'h46) ||
                     (i_byte >= 8'h61 && i_byte <= 8'h66)) begin
            hex_ok = 1'b1;
            hex_v  = i_byte[3:0] + 4'd9;
        end
    end

    assign acc_new    = {r_acc[11:0], hex_v};
    assign acc_hi_sur = (acc_new >= HiSurLo) && (acc_new <= HiSurHi);
    assign acc_lo_sur = (acc_new >= LoSurLo) && (acc_new <= LoSurHi);

    // Code point: plain BMP value, or surrogate pair joined above 0xFFFF
    assign enc_u = (r_phase == jsu_pkg::PH_HEX2)
                 ? ({1'b0, r_high, acc_new[9:0]} + SupBase)
                 : {5'd0, acc_new};

    // UTF-8 encode
    always_comb begin
        enc_bytes = '0;
        enc_last  = 2'd0;
        if (enc_u <= 21'h7F) begin
            enc_bytes[0] = enc_u[7:0];
        end else if (enc_u <= 21'h7FF) begin
            enc_bytes[0] = {3'b110, enc_u[10:6]};
            enc_bytes[1] = {2'b10, enc_u[5:0]};
            enc_last     = 2'd1;
        end else if (enc_u <= 21'hFFFF) begin
            enc_bytes[0] = {4'b1110, enc_u[15:12]};
            enc_bytes[1] = {2'b10, enc_u[11:6]};
            enc_bytes[2] = {2'b10, enc_u[5:0]};
            enc_last     = 2'd2;
        end else begin
            enc_bytes[0] = {5'b11110, enc_u[20:18]};
            enc_bytes[1] = {2'b10, enc_u[17:12]};
            enc_bytes[2] = {2'b10, enc_u[11:6]};
            enc_bytes[3] = {2'b10, enc_u[5:0]};
            enc_last     = 2'd3;
        end
    end

    // Reported length holds at 0xFFFF
    assign cnt_ext = (CntW + 17)'(r_cnt);
    assign len_sat = (cnt_ext > (CntW + 17)'(17'h0FFFF)) ? 16'hFFFF : cnt_ext[15:0];

    // Next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            jsu_pkg::PH_STR: begin
                if (i_byte == ChQuote) begin
                    n_phase = jsu_pkg::PH_IDLE;
                end else if (i_byte == ChBslash) begin
                    n_phase = jsu_pkg::PH_ESC;
                end else if (i_byte < CtrlTop) begin
                    n_phase = jsu_pkg::PH_IDLE;
                end
            end
            jsu_pkg::PH_ESC: begin
                case (i_byte)
                    ChQuote, ChBslash, ChSlash, ChLowB,
                    ChLowF, ChLowN, ChLowT, ChLowR: n_phase = jsu_pkg::PH_STR;
                    ChLowU:  n_phase = jsu_pkg::PH_HEX1;
                    default: n_phase = jsu_pkg::PH_IDLE;
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (!hex_ok) begin
                    n_phase = jsu_pkg::PH_IDLE;
                end else if (r_digits == 2'd3) begin
                    if (r_phase == jsu_pkg::PH_HEX1) begin
                        n_phase = acc_hi_sur ? jsu_pkg::PH_SUR_BS : jsu_pkg::PH_STR;
                    end else begin
                        n_phase = acc_lo_sur ? jsu_pkg::PH_STR : jsu_pkg::PH_IDLE;
                    end
                end
            end
            jsu_pkg::PH_SUR_BS: begin
                n_phase = (i_byte == ChBslash) ? jsu_pkg::PH_SUR_U : jsu_pkg::PH_IDLE;
            end
            jsu_pkg::PH_SUR_U: begin
                n_phase = (i_byte == ChLowU) ? jsu_pkg::PH_HEX2 : jsu_pkg::PH_IDLE;
            end
            default: begin
                n_phase = (i_byte == ChQuote) ? jsu_pkg::PH_STR : jsu_pkg::PH_IDLE;
            end
        endcase
    end

    // Result group and escape state
    always_comb begin
        grp        = '0;
        grp.status = jsu_pkg::ST_DATA;
        n_acc      = r_acc;
        n_high     = r_high;
        n_digits   = r_digits;
        cnt_clear  = 1'b0;
        case (r_phase)
            jsu_pkg::PH_STR: begin
                if (i_byte == ChQuote) begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_DONE;
                    grp.len    = len_sat;
                end else if (i_byte == ChBslash) begin
                    grp.has = 1'b0;
                end else if (i_byte == 8'h00) begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_NOQUOTE;
                end else if (i_byte < CtrlTop) begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_CTRL;
                end else begin
                    grp.has      = 1'b1;
                    grp.bytes[0] = i_byte;
                end
            end
            jsu_pkg::PH_ESC: begin
                grp.has = 1'b1;
                case (i_byte)
                    ChQuote:  grp.bytes[0] = ChQuote;
                    ChBslash: grp.bytes[0] = ChBslash;
                    ChSlash:  grp.bytes[0] = ChSlash;
                    ChLowB:   grp.bytes[0] = 8'h08;
                    ChLowF:   grp.bytes[0] = 8'h0C;
                    ChLowN:   grp.bytes[0] = 8'h0A;
                    ChLowT:   grp.bytes[0] = 8'h09;
                    ChLowR:   grp.bytes[0] = 8'h0D;
                    ChLowU: begin
                        grp.has  = 1'b0;
                        n_acc    = 16'd0;
                        n_digits = 2'd0;
                    end
                    default:  grp.status = jsu_pkg::ST_ESC;
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                if (!hex_ok) begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_HEX;
                end else begin
                    n_acc = acc_new;
                    if (r_digits != 2'd3) begin
                        n_digits = r_digits + 2'd1;
                    end else begin
                        n_digits = 2'd0;
                        if (r_phase == jsu_pkg::PH_HEX1 && acc_hi_sur) begin
                            n_high = acc_new[9:0];
                        end else if (r_phase == jsu_pkg::PH_HEX2 && !acc_lo_sur) begin
                            grp.has    = 1'b1;
                            grp.status = jsu_pkg::ST_SUR;
                        end else begin
                            grp.has      = 1'b1;
                            grp.bytes    = enc_bytes;
                            grp.last_idx = enc_last;
                        end
                    end
                end
            end
            jsu_pkg::PH_SUR_BS: begin
                if (i_byte != ChBslash) begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_SUR;
                end
            end
            jsu_pkg::PH_SUR_U: begin
                if (i_byte == ChLowU) begin
                    n_acc    = 16'd0;
                    n_digits = 2'd0;
                end else begin
                    grp.has    = 1'b1;
                    grp.status = jsu_pkg::ST_SUR;
                end
            end
            default: begin
                cnt_clear = (i_byte == ChQuote);
            end
        endcase
    end

    // Decoded byte count, saturating
    assign cnt_sum = {1'b0, r_cnt} + (CntW + 1)'({1'b0, grp.last_idx}) + (CntW + 1)'(1);
    always_comb begin
        n_cnt = r_cnt;
        if (cnt_clear) begin
            n_cnt = '0;
        end else if (grp.has && grp.status == jsu_pkg::ST_DATA) begin
            n_cnt = (cnt_sum > MaxCnt) ? MaxCnt[CntW-1:0] : cnt_sum[CntW-1:0];
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jsu_pkg::PH_IDLE;
            r_acc    <= 16'd0;
            r_high   <= 10'd0;
            r_digits <= 2'd0;
            r_cnt    <= '0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_high   <= n_high;
            r_digits <= n_digits;
            r_cnt    <= n_cnt;
        end
    end

    assign o_grp = grp;

    // Any ending status leaves the decoder idle
    a_end_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && grp.has && grp.status != jsu_pkg::ST_DATA |=> r_phase == jsu_pkg::PH_IDLE)
        else $error("decoder not idle after string end");

    // Count never passes its ceiling
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_cnt} <= MaxCnt)
        else $error("byte count above limit");

endmodule

// ----- rtl/core/jsu_emit.sv -----
// ----------------------------------------------------------------------------
// jsu_emit
// Result register: holds one group, sends one item per cycle while i_tready.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,    // take i_grp; only when o_free
    input  jsu_pkg::t_group i_grp,
    input  logic            i_tready,
    output logic            o_free,    // group register can load this cycle
    output logic            o_tvalid,
    output logic [7:0]      o_byte,
    output logic [2:0]      o_status,
    output logic [15:0]     o_len,
    output logic            o_last
);

    logic            r_valid;
    logic [1:0]      r_idx;
    jsu_pkg::t_group r_grp;
    logic            take;

    assign take   = r_valid && i_tready;
    assign o_last = (r_idx == r_grp.last_idx);
    assign o_free = !r_valid || (take && o_last);

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take && o_last) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (take) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_grp;
        end
    end

    assign o_tvalid = r_valid;
    assign o_byte   = r_grp.bytes[r_idx];
    assign o_status = r_grp.status;
    assign o_len    = r_grp.len;

    // Index stays inside the group
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_idx <= r_grp.last_idx)
        else $error("result index past group end");

    // Status results are single
    a_status_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_grp.status != jsu_pkg::ST_DATA |-> r_grp.last_idx == 2'd0)
        else $error("status result in multi-item group");

endmodule

// ----- rtl/core/json_string_unescaper.sv -----
// ----------------------------------------------------------------------------
// json_string_unescaper
// Decodes JSON string bodies from a text byte stream into raw UTF-8 bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser       | tlast
//  s_axis   | in  | [7:0] text_byte                | -           | -
//  m_axis   | out | [7:0] out_byte, [23:8] str_len | [2:0] status| last of byte
//
//  Input register -> decoder -> result group register.
//  One input item per cycle while m_axis_tready is high and each byte yields
//  at most one result; a \u escape that encodes to N bytes holds the input
//  until the group register has sent all N, one item per cycle while ready.
//  Reset (i_rst_n low, synchronous) empties both stages and returns to idle.
//  With both stages full, s_axis_tready is m_axis_tready && m_axis_tlast.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
    parameter longint unsigned MAX_LEN = jsu_pkg::MaxLenDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] str_length
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    output logic        m_axis_tlast
);

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            grp_free;
    logic            proc;
    jsu_pkg::t_group grp;
    logic [7:0]      out_byte;
    logic [15:0]     out_len;

    assign proc          = r_in_valid && grp_free;
    assign s_axis_tready = !r_in_valid || proc;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    jsu_decode #(
        .MAX_LEN (MAX_LEN)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (proc),
        .i_byte  (r_in_byte),
        .o_grp   (grp)
    );

    jsu_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (proc && grp.has),
        .i_grp    (grp),
        .i_tready (m_axis_tready),
        .o_free   (grp_free),
        .o_tvalid (m_axis_tvalid),
        .o_byte   (out_byte),
        .o_status (m_axis_tuser),
        .o_len    (out_len),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {out_len, out_byte};

endmodule

// ----- tb/json_string_unescaper_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_test
// Self-checking bench for the JSON string unescaper. Text bytes go in on the
// s_axis side and every decoded item on m_axis is compared against an
// in-bench decoder model: a directed table first, then randomly built
// strings (escapes, \u and surrogate pairs, every error ending).
// ----------------------------------------------------------------------------
module json_string_unescaper_test;

    localparam int          NumTextItems = 210;
    localparam longint      CycleLimit   = 2_000_000;
    localparam logic [7:0]  CH_QUOTE     = 8'h22;
    localparam logic [7:0]  CH_BSLASH    = 8'h5C;
    localparam logic [7:0]  CH_U         = 8'h75;

    // One decoded output item
    typedef struct packed {
        logic [7:0]       out_byte;
        jsu_pkg::t_status status;
        logic [15:0]      str_len;
        logic             last;
    } t_dec_item;

    // Directed row: text byte, plus hand-written outcome where it is obvious
    typedef struct packed {
        logic [7:0]       text;
        logic             typed;
        logic [2:0]       n_items;
        jsu_pkg::t_status status;
        logic [15:0]      str_len;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;           // [7:0] out_byte, [23:8] str_length
    logic [2:0]  m_axis_tuser;           // [2:0] status
    logic        m_axis_tlast;

    json_string_unescaper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Decoder model state
    jsu_pkg::t_phase ph        = jsu_pkg::PH_IDLE;
    logic [15:0]     hex_acc   = '0;
    logic [9:0]      hi_half   = '0;
    logic [1:0]      ndig      = '0;
    longint unsigned dec_count = 0;

    t_dec_item expected_q[$];
    int        mismatches = 0;
    int        checked_items = 0;
    int        text_items = 0;
    int        noise_items = 0;
    int        strings_sent = 0;
    int        last_n = 0;
    bit        idle_on = 1'b1;
    longint    cycles = 0;

    t_dir_row directed_tbl [26] = '{
        '{8'h61,     1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},  // idle: dropped
        '{8'h00,     1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},  // idle NUL: dropped
        '{CH_QUOTE,  1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},  // open
        '{8'hFF,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h20,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h1F,     1'b1, 3'd1, jsu_pkg::ST_CTRL,    16'd0},  // raw control byte
        '{CH_QUOTE,  1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_QUOTE,  1'b1, 3'd1, jsu_pkg::ST_DONE,    16'd0},  // empty string
        '{CH_QUOTE,  1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_BSLASH, 1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h71,     1'b1, 3'd1, jsu_pkg::ST_ESC,     16'd0},  // \q
        '{CH_QUOTE,  1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_BSLASH, 1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_U,      1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h47,     1'b1, 3'd1, jsu_pkg::ST_HEX,     16'd0},  // \uG
        '{CH_QUOTE,  1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_BSLASH, 1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{CH_U,      1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h44,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h38,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h30,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h30,     1'b1, 3'd0, jsu_pkg::ST_DATA,    16'd0},  // high surrogate held
        '{8'h78,     1'b1, 3'd1, jsu_pkg::ST_SUR,     16'd0},  // no \ after it
        '{CH_QUOTE,  1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h41,     1'b0, 3'd0, jsu_pkg::ST_DATA,    16'd0},
        '{8'h00,     1'b1, 3'd1, jsu_pkg::ST_NOQUOTE, 16'd0}   // end of text in string
    };

    // Clock
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 20)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------------
    function automatic void emit_item(logic [7:0] b, jsu_pkg::t_status st,
                                      logic [15:0] len);
        t_dec_item it;
        it.out_byte = b;
        it.status   = st;
        it.str_len  = len;
        it.last     = 1'b0;
        expected_q.insert(expected_q.size(), it);
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        emit_item(b, jsu_pkg::ST_DATA, 16'd0);
        if (dec_count < jsu_pkg::MaxLenDefault)
            dec_count++;
    endfunction

    function automatic void abort_string(jsu_pkg::t_status st);
        emit_item(8'h00, st, 16'd0);
        ph = jsu_pkg::PH_IDLE;
    endfunction

    function automatic void emit_utf8(logic [20:0] u);
        if (u <= 21'h7F) begin
            emit_byte(u[7:0]);
        end else if (u <= 21'h7FF) begin
            emit_byte({3'b110, u[10:6]});
            emit_byte({2'b10, u[5:0]});
        end else if (u <= 21'hFFFF) begin
            emit_byte({4'b1110, u[15:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end else begin
            emit_byte({5'b11110, u[20:18]});
            emit_byte({2'b10, u[17:12]});
            emit_byte({2'b10, u[11:6]});
            emit_byte({2'b10, u[5:0]});
        end
    endfunction

    // Hex digit value, 16 when the byte is not a hex digit
    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        return 16;
    endfunction

    // Advance the model by one text byte, queue its items, return their count
    function automatic int decode_text(logic [7:0] c);
        int start;
        int v;
        start = expected_q.size();
        case (ph)
            jsu_pkg::PH_STR: begin
                if (c == CH_QUOTE) begin
                    emit_item(8'h00, jsu_pkg::ST_DONE,
                              dec_count > 65535 ? 16'hFFFF : dec_count[15:0]);
                    ph = jsu_pkg::PH_IDLE;
                end else if (c == CH_BSLASH) begin
                    ph = jsu_pkg::PH_ESC;
                end else if (c == 8'h00) begin
                    abort_string(jsu_pkg::ST_NOQUOTE);
                end else if (c < 8'h20) begin
                    abort_string(jsu_pkg::ST_CTRL);
                end else begin
                    emit_byte(c);
                end
            end
            jsu_pkg::PH_ESC: begin
                ph = jsu_pkg::PH_STR;
                case (c)
                    CH_QUOTE, CH_BSLASH, "/": emit_byte(c);
                    "b": emit_byte(8'h08);
                    "f": emit_byte(8'h0C);
                    "n": emit_byte(8'h0A);
                    "t": emit_byte(8'h09);
                    "r": emit_byte(8'h0D);
                    CH_U: begin
                        ph      = jsu_pkg::PH_HEX1;
                        hex_acc = '0;
                        ndig    = '0;
                    end
                    default: abort_string(jsu_pkg::ST_ESC);
                endcase
            end
            jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2: begin
                v = hex_value(c);
                if (v > 15) begin
                    abort_string(jsu_pkg::ST_HEX);
                end else begin
                    hex_acc = {hex_acc[11:0], 4'(v)};
                    if (ndig < 2'd3) begin
                        ndig = ndig + 2'd1;
                    end else begin
                        ndig = '0;
                        if (ph == jsu_pkg::PH_HEX1) begin
                            if (hex_acc >= 16'hD800 && hex_acc <= 16'hDBFF) begin
                                hi_half = hex_acc[9:0];
                                ph      = jsu_pkg::PH_SUR_BS;
                            end else begin
                                emit_utf8({5'd0, hex_acc});
                                ph = jsu_pkg::PH_STR;
                            end
                        end else if (hex_acc < 16'hDC00 || hex_acc > 16'hDFFF) begin
                            abort_string(jsu_pkg::ST_SUR);
                        end else begin
                            emit_utf8({1'b0, hi_half, hex_acc[9:0]} + 21'h10000);
                            ph = jsu_pkg::PH_STR;
                        end
                    end
                end
            end
            jsu_pkg::PH_SUR_BS: begin
                if (c == CH_BSLASH) ph = jsu_pkg::PH_SUR_U;
                else abort_string(jsu_pkg::ST_SUR);
            end
            jsu_pkg::PH_SUR_U: begin
                if (c == CH_U) begin
                    ph      = jsu_pkg::PH_HEX2;
                    hex_acc = '0;
                    ndig    = '0;
                end else begin
                    abort_string(jsu_pkg::ST_SUR);
                end
            end
            default: begin
                ph = jsu_pkg::PH_IDLE;
                if (c == CH_QUOTE) begin
                    ph        = jsu_pkg::PH_STR;
                    dec_count = 0;
                end
            end
        endcase
        // Flag the final item of this byte
        if (expected_q.size() > start)
            expected_q[expected_q.size() - 1].last = 1'b1;
        return expected_q.size() - start;
    endfunction

    // ------------------------------------------------------------------------
    // Text source
    // ------------------------------------------------------------------------
    task automatic push_text(input logic [7:0] b);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge i_clk);
        while (s_axis_tready !== 1'b1) @(posedge i_clk);
        last_n = decode_text(b);
        text_items++;
    endtask

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    task automatic push_hex4(input logic [15:0] v);
        push_text(hex_char(v[15:12]));
        push_text(hex_char(v[11:8]));
        push_text(hex_char(v[7:4]));
        push_text(hex_char(v[3:0]));
    endtask

    task automatic push_uescape(input logic [15:0] v);
        push_text(CH_BSLASH);
        push_text(CH_U);
        push_hex4(v);
    endtask

    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        do b = 8'($urandom_range(8'h20, 8'hFF));
        while (b == CH_QUOTE || b == CH_BSLASH);
        return b;
    endfunction

    // One string: opening quote, random body, then a good or a broken ending
    task automatic push_string();
        string       esc_set;
        logic [15:0] v;
        logic [7:0]  b;
        int          ntok;
        esc_set = "\"\\/bfnrt";
        ntok = $urandom_range(0, 8);
        push_text(CH_QUOTE);
        repeat (ntok) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: push_text(plain_char());
                4, 5: begin
                    push_text(CH_BSLASH);
                    push_text(esc_set[$urandom_range(0, 7)]);
                end
                6, 9: begin
                    case ($urandom_range(0, 4))
                        0: v = 16'h0000;
                        1: v = 16'($urandom_range(1, 16'h7F));
                        2: v = 16'($urandom_range(16'h80, 16'h7FF));
                        3: begin
                            do v = 16'($urandom_range(16'h800, 16'hFFFF));
                            while (v >= 16'hD800 && v <= 16'hDBFF);
                        end
                        default: v = 16'($urandom_range(16'hDC00, 16'hDFFF));  // lone low
                    endcase
                    push_uescape(v);
                end
                default: begin
                    push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
                    push_uescape(16'($urandom_range(16'hDC00, 16'hDFFF)));
                end
            endcase
        end
        case ($urandom_range(0, 19))
            13: push_text(8'h00);
            14: push_text(8'($urandom_range(1, 8'h1F)));
            15: begin
                // backslash followed by a byte that is no escape
                push_text(CH_BSLASH);
                if ($urandom_range(0, 3) == 0) begin
                    b = 8'h00;
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_QUOTE || b == CH_BSLASH || b == "/" || b == "b" ||
                           b == "f" || b == "n" || b == "t" || b == "r" || b == CH_U);
                end
                push_text(b);
            end
            16: begin
                // \u cut short by a non-hex byte
                push_text(CH_BSLASH);
                push_text(CH_U);
                repeat ($urandom_range(0, 3)) push_text(hex_char(4'($urandom_range(0, 15))));
                if ($urandom_range(0, 3) == 0) begin
                    b = 8'h00;
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (hex_value(b) < 16);
                end
                push_text(b);
            end
            17: begin
                // high surrogate, then anything but a backslash
                push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
                do b = 8'($urandom_range(0, 255));
                while (b == CH_BSLASH);
                push_text(b);
            end
            18: begin
                // high surrogate, backslash, then anything but u
                push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
                push_text(CH_BSLASH);
                do b = 8'($urandom_range(0, 255));
                while (b == CH_U);
                push_text(b);
            end
            19: begin
                // high surrogate followed by a \u that is no low surrogate
                push_uescape(16'($urandom_range(16'hD800, 16'hDBFF)));
                do v = 16'($urandom_range(0, 16'hFFFF));
                while (v >= 16'hDC00 && v <= 16'hDFFF);
                push_uescape(v);
            end
            default: push_text(CH_QUOTE);
        endcase
        strings_sent++;
    endtask

    // ------------------------------------------------------------------------
    // Result sink and checker
    // ------------------------------------------------------------------------
    task automatic check_item();
        t_dec_item e;
        checked_items++;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected item data=%h status=%0d",
                                      m_axis_tdata, m_axis_tuser));
            return;
        end
        e = expected_q.pop_front();
        if (m_axis_tdata[7:0] !== e.out_byte)
            report_mismatch($sformatf("out_byte got %h want %h",
                                      m_axis_tdata[7:0], e.out_byte));
        if (m_axis_tuser !== e.status)
            report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, e.status));
        if (m_axis_tdata[23:8] !== e.str_len)
            report_mismatch($sformatf("str_length got %0d want %0d",
                                      m_axis_tdata[23:8], e.str_len));
        if (m_axis_tlast !== e.last)
            report_mismatch($sformatf("last got %b want %b", m_axis_tlast, e.last));
    endtask

    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            stall = idle_on ? $urandom_range(0, 5) : 0;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (m_axis_tvalid !== 1'b1) @(posedge i_clk);
            check_item();
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table
        for (int i = 0; i < 26; i++) begin
            push_text(directed_tbl[i].text);
            if (directed_tbl[i].typed) begin
                if (last_n != int'(directed_tbl[i].n_items))
                    report_mismatch($sformatf("row %0d: model gave %0d items, table %0d",
                                              i, last_n, directed_tbl[i].n_items));
                else if (last_n == 1 &&
                         (expected_q[$].status != directed_tbl[i].status ||
                          expected_q[$].str_len != directed_tbl[i].str_len))
                    report_mismatch($sformatf("row %0d: model status %0d, table %0d",
                                              i, expected_q[$].status,
                                              directed_tbl[i].status));
            end
        end

        // Random strings with noise between them
        while (text_items < NumTextItems) begin
            idle_on = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(0, 3)) begin
                logic [7:0] nb;
                do nb = 8'($urandom_range(0, 255));
                while (nb == CH_QUOTE);
                push_text(nb);
                noise_items++;
            end
            push_string();
        end
        idle_on = 1'b1;
        s_axis_tvalid <= 1'b0;

        // Drain
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d text bytes (%0d noise) in %0d strings; checked %0d output items",
                 text_items, noise_items, strings_sent, checked_items);
        $display("Covered escapes, \\u and surrogate pairs, and all error endings");
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
